>>> src/cec_pkg.sv
// ----------------------------------------------------------------------------
// cec_pkg
// Shared types for the circle event circumcentre pipeline.
// ----------------------------------------------------------------------------
package cec_pkg;

  // control bits that travel with each request down the pipeline
  typedef struct packed {
    logic vld;
    logic ok;
  } cec_ctl_t;

  // strict mode value of the configuration register
  localparam logic MODE_STRICT = 1'b1;

endpackage

>>> src/circle_event_circumcenter_unit.sv
// ----------------------------------------------------------------------------
// circle_event_circumcenter_unit
// Circumcentre and lowest circle point of three sites for circle events.
// ----------------------------------------------------------------------------
//  channel  | ports                                  | flow
//  ---------+----------------------------------------+---------------------------
//  request  | start, busy, in_point_*                | taken on start & !busy
//  result   | out_strobe, out_*                      | one cycle, no back-pressure
//  config   | cfg_valid, cfg_ready, cfg_data         | taken on valid & ready
//
//  A request enters every cycle; busy stays low and cfg_ready stays high.
//  Most of the pipeline depth comes from the two bit-serial pipelines:
//  one stage per quotient bit and one per root bit.
//  Synchronous active-low reset clears the valid bits and sets strict mode.
//  Nothing stalls: results leave on the strobe and cannot be held off.
// ----------------------------------------------------------------------------
module circle_event_circumcenter_unit import cec_pkg::*; #(
  parameter int COORD_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic signed [COORD_WIDTH-1:0]  in_point_p_x,
  input  logic signed [COORD_WIDTH-1:0]  in_point_p_y,
  input  logic signed [COORD_WIDTH-1:0]  in_point_q_x,
  input  logic signed [COORD_WIDTH-1:0]  in_point_q_y,
  input  logic signed [COORD_WIDTH-1:0]  in_point_r_x,
  input  logic signed [COORD_WIDTH-1:0]  in_point_r_y,
  output logic                           out_strobe,
  output logic                           out_converges,
  output logic signed [COORD_WIDTH-1:0]  out_center_x,
  output logic signed [COORD_WIDTH-1:0]  out_center_y,
  output logic signed [COORD_WIDTH-1:0]  out_lowest_y,
  output logic                           out_saturated,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic                           cfg_data
);

  localparam int W = COORD_WIDTH;
  localparam int DW = 2 * W + 5;
  localparam int RW = W + 1;
  localparam logic signed [W+2:0] HI3 = {4'b0000, {(W-1){1'b1}}};
  localparam logic signed [W+2:0] LO3 = {4'b1111, {(W-1){1'b0}}};

  // clip to the coordinate range, flag in the top bit
  function automatic logic [W:0] clip3(input logic signed [W+2:0] v);
    logic [W:0] res;
    if (v > HI3) begin
      res = {1'b1, HI3[W-1:0]};
    end else if (v < LO3) begin
      res = {1'b1, LO3[W-1:0]};
    end else begin
      res = {1'b0, v[W-1:0]};
    end
    return res;
  endfunction

  // configuration register
  logic strict_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r <= MODE_STRICT;
    end else if (cfg_valid && cfg_ready) begin
      strict_r <= cfg_data;
    end
  end

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  // front end up to dividend and divisor
  cec_ctl_t          ctl_f;
  logic [3*W+4:0]    num_y_f, num_x_f;
  logic [DW-1:0]     div_f;
  logic              neg_y_f, neg_x_f;
  logic signed [W-1:0] qx_f, qy_f;

  cec_front #(.W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .vld_i    (start && !busy),
    .strict_i (strict_r),
    .px_i     (in_point_p_x),
    .py_i     (in_point_p_y),
    .qx_i     (in_point_q_x),
    .qy_i     (in_point_q_y),
    .rx_i     (in_point_r_x),
    .ry_i     (in_point_r_y),
    .ctl_o    (ctl_f),
    .num_y_o  (num_y_f),
    .num_x_o  (num_x_f),
    .div_o    (div_f),
    .neg_y_o  (neg_y_f),
    .neg_x_o  (neg_x_f),
    .qx_o     (qx_f),
    .qy_o     (qy_f)
  );

  // rounding dividers for centre y and centre x
  cec_ctl_t          ctl_dv;
  logic [W-1:0]      quo_y, quo_x;
  logic              ovf_y, ovf_x;
  logic [2*W:0]      pay_y;
  logic              pay_x;

  cec_div #(.DW(DW), .QW(W), .PW(2*W+1)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_f),
    .num_i (num_y_f),
    .div_i (div_f),
    .pay_i ({neg_y_f, qx_f, qy_f}),
    .ctl_o (ctl_dv),
    .quo_o (quo_y),
    .ovf_o (ovf_y),
    .pay_o (pay_y)
  );

  cec_div #(.DW(DW), .QW(W), .PW(1)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl_i (ctl_f),
    .num_i (num_x_f),
    .div_i (div_f),
    .pay_i (neg_x_f),
    .ctl_o (),
    .quo_o (quo_x),
    .ovf_o (ovf_x),
    .pay_o (pay_x)
  );

  // stage g: sign, saturation of the centre (x is the negated quotient)
  logic signed [W+2:0] vy, vx;
  logic [W:0]          cy_clip, cx_clip;
  logic signed [W-1:0] cy_g, cx_g;
  logic                sat_g;

  assign vy = pay_y[2*W] ? -$signed({3'b000, quo_y}) : $signed({3'b000, quo_y});
  assign vx = pay_x ? $signed({3'b000, quo_x}) : -$signed({3'b000, quo_x});
  assign cy_clip = clip3(vy);
  assign cx_clip = clip3(vx);

  always_comb begin
    cy_g = cy_clip[W-1:0];
    cx_g = cx_clip[W-1:0];
    if (ovf_y) begin
      cy_g = pay_y[2*W] ? LO3[W-1:0] : HI3[W-1:0];
    end
    if (ovf_x) begin
      cx_g = pay_x ? HI3[W-1:0] : LO3[W-1:0];
    end
    sat_g = ovf_y || ovf_x || (!ovf_y && cy_clip[W]) || (!ovf_x && cx_clip[W]);
  end

  cec_ctl_t            ctl_g_r;
  logic signed [W-1:0] cy_g_r, cx_g_r, qx_g_r, qy_g_r;
  logic                sat_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_g_r <= '0;
    end else begin
      ctl_g_r <= ctl_dv;
    end
    cy_g_r  <= cy_g;
    cx_g_r  <= cx_g;
    qx_g_r  <= pay_y[2*W-1:W];
    qy_g_r  <= pay_y[W-1:0];
    sat_g_r <= sat_g;
  end

  // stage h: offset of q from the centre
  cec_ctl_t            ctl_h_r;
  logic signed [W:0]   dx_h_r, dy_h_r;
  logic signed [W-1:0] cx_h_r, cy_h_r;
  logic                sat_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_h_r <= '0;
    end else begin
      ctl_h_r <= ctl_g_r;
    end
    dx_h_r  <= (W+1)'(cx_g_r) - (W+1)'(qx_g_r);
    dy_h_r  <= (W+1)'(cy_g_r) - (W+1)'(qy_g_r);
    cx_h_r  <= cx_g_r;
    cy_h_r  <= cy_g_r;
    sat_h_r <= sat_g_r;
  end

  // stage i: squared offsets
  cec_ctl_t              ctl_i_r;
  logic signed [2*W+1:0] dx2_i_r, dy2_i_r;
  logic signed [W-1:0]   cx_i_r, cy_i_r;
  logic                  sat_i_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_i_r <= '0;
    end else begin
      ctl_i_r <= ctl_h_r;
    end
    dx2_i_r <= dx_h_r * dx_h_r;
    dy2_i_r <= dy_h_r * dy_h_r;
    cx_i_r  <= cx_h_r;
    cy_i_r  <= cy_h_r;
    sat_i_r <= sat_h_r;
  end

  // radius by square root of the summed squares
  logic [2*W+1:0] rad_sum;
  cec_ctl_t       ctl_sq;
  logic [RW:0]    root_sq;
  logic [2*W:0]   pay_sq;

  assign rad_sum = dx2_i_r + dy2_i_r;

  cec_sqrt #(.SW(2*W+2), .RW(RW), .PW(2*W+1)) u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl_i  (ctl_i_r),
    .rad_i  (rad_sum),
    .pay_i  ({sat_i_r, cx_i_r, cy_i_r}),
    .ctl_o  (ctl_sq),
    .root_o (root_sq),
    .pay_o  (pay_sq)
  );

  // output stage: lowest point, rejected requests read as zero
  logic signed [W+2:0] vl;
  logic [W:0]          low_clip;

  assign vl = (W+3)'($signed(pay_sq[W-1:0])) - $signed({1'b0, root_sq});
  assign low_clip = clip3(vl);

  logic                out_strobe_r, out_conv_r, out_sat_r;
  logic signed [W-1:0] out_cx_r, out_cy_r, out_low_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= ctl_sq.vld;
    end
    out_conv_r <= ctl_sq.ok;
    out_cx_r   <= ctl_sq.ok ? pay_sq[2*W-1:W] : '0;
    out_cy_r   <= ctl_sq.ok ? pay_sq[W-1:0] : '0;
    out_low_r  <= ctl_sq.ok ? low_clip[W-1:0] : '0;
    out_sat_r  <= ctl_sq.ok && (pay_sq[2*W] || low_clip[W]);
  end

  assign out_strobe    = out_strobe_r;
  assign out_converges = out_strobe_r && out_conv_r;
  assign out_center_x  = out_cx_r;
  assign out_center_y  = out_cy_r;
  assign out_lowest_y  = out_low_r;
  assign out_saturated = out_sat_r;

`ifndef NO_ASSERTIONS
  // the circle bottom never lies above its centre
  a_low_below_centre: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_converges) |-> (out_lowest_y <= out_center_y))
    else $error("lowest point above centre");

  // reset empties the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("result strobe right after reset");

  // a rejected triple never reports clipping
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_converges) |-> (!out_saturated && out_lowest_y == '0))
    else $error("rejected triple carries data");
`endif

endmodule

>>> src/cec_front.sv
// ----------------------------------------------------------------------------
// cec_front
// Differences, squares, orientation determinant and circumcentre numerators,
// ending in the unsigned dividend and divisor for the rounding dividers.
// ----------------------------------------------------------------------------
module cec_front import cec_pkg::*; #(
  parameter int W = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 vld_i,
  input  logic                 strict_i,
  input  logic signed [W-1:0]  px_i,
  input  logic signed [W-1:0]  py_i,
  input  logic signed [W-1:0]  qx_i,
  input  logic signed [W-1:0]  qy_i,
  input  logic signed [W-1:0]  rx_i,
  input  logic signed [W-1:0]  ry_i,
  output cec_ctl_t             ctl_o,
  output logic [3*W+4:0]       num_y_o,
  output logic [3*W+4:0]       num_x_o,
  output logic [2*W+4:0]       div_o,
  output logic                 neg_y_o,
  output logic                 neg_x_o,
  output logic signed [W-1:0]  qx_o,
  output logic signed [W-1:0]  qy_o
);

  localparam int DW = W + 1;
  localparam int MW = 2 * W + 2;
  localparam int NYW = 3 * W + 4;

  // stage a: request registers
  cec_ctl_t ctl_a_r;
  logic signed [W-1:0] px_a_r, py_a_r, qx_a_r, qy_a_r, rx_a_r, ry_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_a_r <= '0;
    end else begin
      ctl_a_r <= '{vld: vld_i, ok: 1'b0};
    end
    px_a_r <= px_i;
    py_a_r <= py_i;
    qx_a_r <= qx_i;
    qy_a_r <= qy_i;
    rx_a_r <= rx_i;
    ry_a_r <= ry_i;
  end

  // stage b: edge vectors and coordinate squares
  cec_ctl_t ctl_b_r;
  logic signed [DW-1:0] dpx_b_r, dpy_b_r, drx_b_r, dry_b_r;
  logic signed [2*W-1:0] spx_b_r, spy_b_r, sqx_b_r, sqy_b_r, srx_b_r, sry_b_r;
  logic signed [W-1:0] qx_b_r, qy_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_b_r <= '0;
    end else begin
      ctl_b_r <= ctl_a_r;
    end
    dpx_b_r <= DW'(px_a_r) - DW'(qx_a_r);
    dpy_b_r <= DW'(py_a_r) - DW'(qy_a_r);
    drx_b_r <= DW'(qx_a_r) - DW'(rx_a_r);
    dry_b_r <= DW'(qy_a_r) - DW'(ry_a_r);
    spx_b_r <= px_a_r * px_a_r;
    spy_b_r <= py_a_r * py_a_r;
    sqx_b_r <= qx_a_r * qx_a_r;
    sqy_b_r <= qy_a_r * qy_a_r;
    srx_b_r <= rx_a_r * rx_a_r;
    sry_b_r <= ry_a_r * ry_a_r;
    qx_b_r  <= qx_a_r;
    qy_b_r  <= qy_a_r;
  end

  // stage c: determinant products and squared-norm differences
  cec_ctl_t ctl_c_r;
  logic signed [MW-1:0] m1_c_r, m2_c_r, t1_c_r, t2_c_r;
  logic signed [DW-1:0] dpx_c_r, dpy_c_r, drx_c_r, dry_c_r;
  logic signed [W-1:0] qx_c_r, qy_c_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_c_r <= '0;
    end else begin
      ctl_c_r <= ctl_b_r;
    end
    m1_c_r  <= dpy_b_r * drx_b_r;
    m2_c_r  <= dry_b_r * dpx_b_r;
    t1_c_r  <= (MW'(srx_b_r) + MW'(sry_b_r)) - (MW'(sqx_b_r) + MW'(sqy_b_r));
    t2_c_r  <= (MW'(sqx_b_r) + MW'(sqy_b_r)) - (MW'(spx_b_r) + MW'(spy_b_r));
    dpx_c_r <= dpx_b_r;
    dpy_c_r <= dpy_b_r;
    drx_c_r <= drx_b_r;
    dry_c_r <= dry_b_r;
    qx_c_r  <= qx_b_r;
    qy_c_r  <= qy_b_r;
  end

  // stage d: determinant and split partial products of the numerators
  logic signed [W+1:0] t1h, t2h;
  logic signed [W:0]   t1l, t2l;

  assign t1h = t1_c_r[2*W+1:W];
  assign t2h = t2_c_r[2*W+1:W];
  assign t1l = $signed({1'b0, t1_c_r[W-1:0]});
  assign t2l = $signed({1'b0, t2_c_r[W-1:0]});

  cec_ctl_t ctl_d_r;
  logic signed [2*W+2:0] det_d_r;
  logic signed [2*W+2:0] ayh_d_r, byh_d_r, axh_d_r, bxh_d_r;
  logic signed [2*W+1:0] ayl_d_r, byl_d_r, axl_d_r, bxl_d_r;
  logic signed [W-1:0] qx_d_r, qy_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_d_r <= '0;
    end else begin
      ctl_d_r <= ctl_c_r;
    end
    det_d_r <= (2*W+3)'(m1_c_r) - (2*W+3)'(m2_c_r);
    ayh_d_r <= t1h * dpx_c_r;
    byh_d_r <= t2h * drx_c_r;
    axh_d_r <= t1h * dpy_c_r;
    bxh_d_r <= t2h * dry_c_r;
    ayl_d_r <= t1l * dpx_c_r;
    byl_d_r <= t2l * drx_c_r;
    axl_d_r <= t1l * dpy_c_r;
    bxl_d_r <= t2l * dry_c_r;
    qx_d_r  <= qx_c_r;
    qy_d_r  <= qy_c_r;
  end

  // stage e: numerators, doubled determinant and acceptance
  logic accept_e;

  assign accept_e = (strict_i == MODE_STRICT) ? (!det_d_r[2*W+2] && (det_d_r != '0))
                                              : (det_d_r != '0);

  cec_ctl_t ctl_e_r;
  logic signed [NYW-1:0] ny_e_r, nx_e_r;
  logic signed [2*W+3:0] den_e_r;
  logic signed [W-1:0] qx_e_r, qy_e_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_e_r <= '0;
    end else begin
      ctl_e_r <= '{vld: ctl_d_r.vld, ok: accept_e};
    end
    ny_e_r  <= (NYW'((2*W+4)'(ayh_d_r) - (2*W+4)'(byh_d_r)) <<< W)
             + NYW'((2*W+3)'(ayl_d_r) - (2*W+3)'(byl_d_r));
    nx_e_r  <= (NYW'((2*W+4)'(axh_d_r) - (2*W+4)'(bxh_d_r)) <<< W)
             + NYW'((2*W+3)'(axl_d_r) - (2*W+3)'(bxl_d_r));
    den_e_r <= (2*W+4)'(det_d_r) <<< 1;
    qx_e_r  <= qx_d_r;
    qy_e_r  <= qy_d_r;
  end

  // stage f: magnitudes for round-to-nearest division
  logic [NYW-1:0]   abs_ny, abs_nx;
  logic [2*W+3:0]   abs_den;

  assign abs_ny  = ny_e_r[NYW-1] ? -ny_e_r : ny_e_r;
  assign abs_nx  = nx_e_r[NYW-1] ? -nx_e_r : nx_e_r;
  assign abs_den = den_e_r[2*W+3] ? -den_e_r : den_e_r;

  cec_ctl_t ctl_f_r;
  logic [3*W+4:0] num_y_f_r, num_x_f_r;
  logic [2*W+4:0] div_f_r;
  logic neg_y_f_r, neg_x_f_r;
  logic signed [W-1:0] qx_f_r, qy_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_f_r <= '0;
    end else begin
      ctl_f_r <= ctl_e_r;
    end
    num_y_f_r <= {abs_ny, 1'b0} + (3*W+5)'(abs_den);
    num_x_f_r <= {abs_nx, 1'b0} + (3*W+5)'(abs_den);
    div_f_r   <= {abs_den, 1'b0};
    neg_y_f_r <= ny_e_r[NYW-1] ^ den_e_r[2*W+3];
    neg_x_f_r <= nx_e_r[NYW-1] ^ den_e_r[2*W+3];
    qx_f_r    <= qx_e_r;
    qy_f_r    <= qy_e_r;
  end

  assign ctl_o   = ctl_f_r;
  assign num_y_o = num_y_f_r;
  assign num_x_o = num_x_f_r;
  assign div_o   = div_f_r;
  assign neg_y_o = neg_y_f_r;
  assign neg_x_o = neg_x_f_r;
  assign qx_o    = qx_f_r;
  assign qy_o    = qy_f_r;

endmodule

>>> src/cec_div.sv
// ----------------------------------------------------------------------------
// cec_div
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in QW bits.
// ----------------------------------------------------------------------------
module cec_div import cec_pkg::*; #(
  parameter int DW = 69,
  parameter int QW = 32,
  parameter int PW = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cec_ctl_t          ctl_i,
  input  logic [DW+QW-1:0]  num_i,
  input  logic [DW-1:0]     div_i,
  input  logic [PW-1:0]     pay_i,
  output cec_ctl_t          ctl_o,
  output logic [QW-1:0]     quo_o,
  output logic              ovf_o,
  output logic [PW-1:0]     pay_o
);

  cec_ctl_t        ctl_r [QW+1];
  logic [DW-1:0]   rem_r [QW+1];
  logic [QW-1:0]   lo_r  [QW+1];
  logic [QW-1:0]   quo_r [QW+1];
  logic [DW-1:0]   div_r [QW+1];
  logic            ovf_r [QW+1];
  logic [PW-1:0]   pay_r [QW+1];

  // entry stage: overflow check, upper dividend bits seed the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
    end
    rem_r[0] <= num_i[DW+QW-1:QW];
    lo_r[0]  <= num_i[QW-1:0];
    quo_r[0] <= '0;
    div_r[0] <= div_i;
    ovf_r[0] <= (num_i[DW+QW-1:QW] >= div_i);
    pay_r[0] <= pay_i;
  end

  // one compare and subtract per stage
  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic        take;

    assign trial = {rem_r[k], lo_r[k][QW-1]};
    assign take  = (trial >= {1'b0, div_r[k]});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
      rem_r[k+1] <= take ? DW'(trial - {1'b0, div_r[k]}) : trial[DW-1:0];
      lo_r[k+1]  <= {lo_r[k][QW-2:0], 1'b0};
      quo_r[k+1] <= {quo_r[k][QW-2:0], take};
      div_r[k+1] <= div_r[k];
      ovf_r[k+1] <= ovf_r[k];
      pay_r[k+1] <= pay_r[k];
    end
  end

  assign ctl_o = ctl_r[QW];
  assign quo_o = quo_r[QW];
  assign ovf_o = ovf_r[QW];
  assign pay_o = pay_r[QW];

endmodule

>>> src/cec_sqrt.sv
// ----------------------------------------------------------------------------
// cec_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage,
// then rounding to nearest.
// ----------------------------------------------------------------------------
module cec_sqrt import cec_pkg::*; #(
  parameter int SW = 66,
  parameter int RW = 33,
  parameter int PW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  cec_ctl_t        ctl_i,
  input  logic [SW-1:0]   rad_i,
  input  logic [PW-1:0]   pay_i,
  output cec_ctl_t        ctl_o,
  output logic [RW:0]     root_o,
  output logic [PW-1:0]   pay_o
);

  localparam int XW = 2 * RW + 1;

  cec_ctl_t        ctl_r  [RW+1];
  logic [XW-1:0]   rem_r  [RW+1];
  logic [RW-1:0]   root_r [RW+1];
  logic [PW-1:0]   pay_r  [RW+1];

  // entry stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r[0] <= '0;
    end else begin
      ctl_r[0] <= ctl_i;
    end
    rem_r[0]  <= XW'(rad_i);
    root_r[0] <= '0;
    pay_r[0]  <= pay_i;
  end

  // root bit RW-1-k decided in stage k
  for (genvar k = 0; k < RW; k++) begin : g_bit
    localparam int B = RW - 1 - k;
    logic [XW-1:0] trial;
    logic          take;

    assign trial = (XW'(root_r[k]) << (B + 1)) + (XW'(1) << (2 * B));
    assign take  = (rem_r[k] >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[k+1] <= '0;
      end else begin
        ctl_r[k+1] <= ctl_r[k];
      end
      rem_r[k+1]  <= take ? rem_r[k] - trial : rem_r[k];
      root_r[k+1] <= take ? (root_r[k] | (RW'(1) << B)) : root_r[k];
      pay_r[k+1]  <= pay_r[k];
    end
  end

  // round to nearest: step up when the remainder exceeds the root
  cec_ctl_t      ctl_out_r;
  logic [RW:0]   root_out_r;
  logic [PW-1:0] pay_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_out_r <= '0;
    end else begin
      ctl_out_r <= ctl_r[RW];
    end
    root_out_r <= (RW+1)'(root_r[RW])
                + (RW+1)'(rem_r[RW] > XW'(root_r[RW]));
    pay_out_r  <= pay_r[RW];
  end

  assign ctl_o  = ctl_out_r;
  assign root_o = root_out_r;
  assign pay_o  = pay_out_r;

endmodule
